>>> rtl/ura_pkg.sv
// Shared types and constants of the ultrasonic range averager.
`default_nettype none
package ura_pkg;

	typedef struct packed {
		logic start_req;
		logic echo;
	} tick_t;

	typedef struct packed {
		logic        trigger;
		logic        busy_res;
		logic        done_res;
		logic [22:0] distance_centi_cm;
	} result_t;

	// control part of one queued word
	typedef struct packed {
		logic trigger;
		logic busy;
		logic done;
	} ctl_t;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_US   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_US       = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_US_PER_CM    = 8'd3;

	localparam logic [9:0]  TRIGGER_US_RST   = 10'd20;
	localparam logic [19:0] GAP_US_RST       = 20'd50000;
	localparam logic [4:0]  SAMPLE_COUNT_RST = 5'd5;
	localparam logic [7:0]  US_PER_CM_RST    = 8'd58;

	localparam int N_W = 5;
	localparam int UPC_W = 8;
	localparam int DEN_W = N_W + UPC_W;
	localparam int DIST_W = 23;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [6:0] CENTI_PER_CM = 7'd100;

	localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

>>> rtl/ura_queue.sv
// Small word queue between the tick front end and the result back end.
`default_nettype none
module ura_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              full,
	output logic              nonempty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && nonempty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ura_front.sv
// Per-tick ranging sequencer: trigger, echo timing, sample accumulation.
`default_nettype none
module ura_front #(
	parameter int ECHO_BITS = 16,
	parameter int MAX_SAMPLES = 16,
	parameter int SUM_W = 21
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire ura_pkg::tick_t            tick,
	input  wire logic [9:0]                trigger_us,
	input  wire logic [19:0]               gap_us,
	input  wire logic [ura_pkg::N_W-1:0]   sample_count,
	input  wire logic [ura_pkg::UPC_W-1:0] us_per_cm,
	output ura_pkg::ctl_t                  ctl,
	output logic [SUM_W-1:0]               sum,
	output logic [ura_pkg::N_W-1:0]        n,
	output logic [ura_pkg::UPC_W-1:0]      upc
);
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_TRIG  = 3'd1;
	localparam logic [2:0] PH_WAIT  = 3'd2;
	localparam logic [2:0] PH_COUNT = 3'd3;
	localparam logic [2:0] PH_GAP   = 3'd4;

	logic [2:0]              phase_q, phase_d;
	logic [19:0]             timer_q, timer_d, timer_inc;
	logic [ECHO_BITS-1:0]    ticks_q, ticks_d;
	logic [SUM_W-1:0]        sum_q, sum_d;
	logic [ura_pkg::N_W-1:0] sdone_q, sdone_d, sdone_inc;
	logic [19:0]             trig_w;
	logic [ura_pkg::N_W-1:0] eff_n;
	logic                    trig;
	logic                    done;

	assign trig_w = (trigger_us == '0) ? 20'd1 : {10'd0, trigger_us};
	assign timer_inc = timer_q + 20'd1;
	assign sdone_inc = sdone_q + 1'b1;

	always_comb begin
		if (sample_count == '0) begin
			eff_n = ura_pkg::N_W'(1);
		end else if (32'(sample_count) > MAX_SAMPLES) begin
			eff_n = ura_pkg::N_W'(MAX_SAMPLES);
		end else begin
			eff_n = sample_count;
		end
	end

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		ticks_d = ticks_q;
		sum_d = sum_q;
		sdone_d = sdone_q;
		trig = 1'b0;
		done = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (tick.start_req) begin
					sum_d = '0;
					sdone_d = '0;
					ticks_d = '0;
					trig = 1'b1;
					timer_d = 20'd1;
					phase_d = (20'd1 >= trig_w) ? PH_WAIT : PH_TRIG;
				end
			end
			PH_TRIG: begin
				trig = 1'b1;
				timer_d = timer_inc;
				if (timer_inc >= trig_w) begin
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (tick.echo) begin
					ticks_d = ECHO_BITS'(1);
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (tick.echo) begin
					if (ticks_q != '1) begin
						ticks_d = ticks_q + 1'b1;
					end
				end else begin
					sum_d = sum_q + SUM_W'(ticks_q);
					sdone_d = sdone_inc;
					if (sdone_inc >= eff_n) begin
						done = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						timer_d = '0;
						phase_d = (gap_us == '0) ? PH_TRIG : PH_GAP;
					end
				end
			end
			PH_GAP: begin
				if (timer_inc >= gap_us) begin
					timer_d = '0;
					phase_d = PH_TRIG;
				end else begin
					timer_d = timer_inc;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	assign ctl.trigger = trig;
	assign ctl.busy = (phase_d != PH_IDLE);
	assign ctl.done = done;
	assign sum = sum_d;
	assign n = eff_n;
	assign upc = (us_per_cm == '0) ? ura_pkg::UPC_W'(1) : us_per_cm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			ticks_q <= '0;
			sum_q <= '0;
			sdone_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			ticks_q <= ticks_d;
			sum_q <= sum_d;
			sdone_q <= sdone_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ura_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ura_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [NUM_W-1:0]      quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign fits = (rem_sh >= {1'b0, den_q});
	assign busy = busy_q;
	assign quot = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

endmodule
`default_nettype wire

>>> rtl/ura_back.sv
// Result stage: passes queued words out, divides the sum on a done word.
`default_nettype none
module ura_back #(
	parameter int SUM_W = 21
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_valid,
	output logic                           q_pop,
	input  wire ura_pkg::ctl_t             ctl,
	input  wire logic [SUM_W-1:0]          sum,
	input  wire logic [ura_pkg::N_W-1:0]   n,
	input  wire logic [ura_pkg::UPC_W-1:0] upc,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output ura_pkg::result_t               result
);
	localparam int NUM_W = SUM_W + 7;
	localparam int QW = (NUM_W > ura_pkg::DIST_W) ? NUM_W : ura_pkg::DIST_W;
	localparam logic BK_IDLE = 1'b0;
	localparam logic BK_DIV  = 1'b1;

	logic                        bk_q;
	logic                        res_valid_q;
	ura_pkg::result_t            res_q;
	ura_pkg::ctl_t               ctl_hold_q;
	logic [ura_pkg::DIST_W-1:0]  last_q;
	logic                        load_ok;
	logic                        div_start;
	logic                        div_busy;
	logic                        finish;
	logic [NUM_W-1:0]            num;
	logic [ura_pkg::DEN_W-1:0]   den;
	logic [NUM_W-1:0]            quot;
	logic [QW-1:0]               q_ext;
	logic [ura_pkg::DIST_W-1:0]  dist_sat;

	assign load_ok = !res_valid_q || !result_stall;
	assign num = NUM_W'(sum) * NUM_W'(ura_pkg::CENTI_PER_CM);
	assign den = ura_pkg::DEN_W'(n) * ura_pkg::DEN_W'(upc);
	assign q_ext = QW'(quot);
	assign dist_sat = (q_ext > QW'(ura_pkg::DIST_MAX)) ? ura_pkg::DIST_MAX
		: q_ext[ura_pkg::DIST_W-1:0];
	assign finish = (bk_q == BK_DIV) && !div_busy && load_ok;

	always_comb begin
		q_pop = 1'b0;
		div_start = 1'b0;
		if (bk_q == BK_IDLE && q_valid) begin
			if (ctl.done) begin
				q_pop = 1'b1;
				div_start = 1'b1;
			end else if (load_ok) begin
				q_pop = 1'b1;
			end
		end
	end

	ura_div #(
		.NUM_W(NUM_W),
		.DEN_W(ura_pkg::DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   (den),
		.busy  (div_busy),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_q <= BK_IDLE;
			res_valid_q <= 1'b0;
			last_q <= '0;
		end else begin
			if (div_start) begin
				bk_q <= BK_DIV;
			end else if (finish) begin
				bk_q <= BK_IDLE;
				last_q <= dist_sat;
			end
			if ((q_pop && !ctl.done) || finish) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			ctl_hold_q <= ctl;
		end
		if (q_pop && !ctl.done) begin
			res_q <= '{trigger: ctl.trigger, busy_res: ctl.busy, done_res: 1'b0,
				distance_centi_cm: last_q};
		end else if (finish) begin
			res_q <= '{trigger: ctl_hold_q.trigger, busy_res: ctl_hold_q.busy,
				done_res: 1'b1, distance_centi_cm: dist_sat};
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule
`default_nettype wire

>>> rtl/ultrasonic_range_averager.sv
// Top level of the ultrasonic range averager: registers, front end, queue, back end.
//
// Each tick word gives exactly one result word, in order. The front end takes one
// tick word per clock while the four-word queue has room; ordinary ticks pass
// through the queue and the result register. The tick that ends the last echo of a
// measurement also carries the averaged distance, computed by a one-bit-per-cycle
// divider of ECHO_BITS + clog2(MAX_SAMPLES+1) + 7 bits, so that word waits for the
// divider and the queue can fill, holding off further ticks once per measurement.
// Between done ticks the rate is one tick per cycle while result_stall is low.
`default_nettype none
module ultrasonic_range_averager #(
	parameter int ECHO_BITS = 16,
	parameter int MAX_SAMPLES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tick_valid,
	output logic                               tick_stall,
	input  wire ura_pkg::tick_t                tick,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output ura_pkg::result_t                   result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ura_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ura_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int SUM_W = ECHO_BITS + $clog2(MAX_SAMPLES + 1);
	localparam int EW = $bits(ura_pkg::ctl_t) + SUM_W + ura_pkg::N_W + ura_pkg::UPC_W;

	logic [9:0]                trigger_us_q;
	logic [19:0]               gap_us_q;
	logic [ura_pkg::N_W-1:0]   sample_count_q;
	logic [ura_pkg::UPC_W-1:0] us_per_cm_q;

	logic                      accept;
	ura_pkg::ctl_t             f_ctl, b_ctl;
	logic [SUM_W-1:0]          f_sum, b_sum;
	logic [ura_pkg::N_W-1:0]   f_n, b_n;
	logic [ura_pkg::UPC_W-1:0] f_upc, b_upc;
	logic [EW-1:0]             q_rdata;
	logic                      q_full;
	logic                      q_nonempty;
	logic                      q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_us_q <= ura_pkg::TRIGGER_US_RST;
			gap_us_q <= ura_pkg::GAP_US_RST;
			sample_count_q <= ura_pkg::SAMPLE_COUNT_RST;
			us_per_cm_q <= ura_pkg::US_PER_CM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ura_pkg::REG_TRIGGER_US:   trigger_us_q <= cfg_data[9:0];
				ura_pkg::REG_GAP_US:       gap_us_q <= cfg_data[19:0];
				ura_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data[ura_pkg::N_W-1:0];
				ura_pkg::REG_US_PER_CM:    us_per_cm_q <= cfg_data[ura_pkg::UPC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign tick_stall = q_full;
	assign accept = tick_valid && !tick_stall;

	ura_front #(
		.ECHO_BITS  (ECHO_BITS),
		.MAX_SAMPLES(MAX_SAMPLES),
		.SUM_W      (SUM_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.tick        (tick),
		.trigger_us  (trigger_us_q),
		.gap_us      (gap_us_q),
		.sample_count(sample_count_q),
		.us_per_cm   (us_per_cm_q),
		.ctl         (f_ctl),
		.sum         (f_sum),
		.n           (f_n),
		.upc         (f_upc)
	);

	ura_queue #(
		.W    (EW),
		.DEPTH(ura_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.wdata   ({f_ctl, f_sum, f_n, f_upc}),
		.pop     (q_pop),
		.rdata   (q_rdata),
		.full    (q_full),
		.nonempty(q_nonempty)
	);

	assign {b_ctl, b_sum, b_n, b_upc} = q_rdata;

	ura_back #(
		.SUM_W(SUM_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_nonempty),
		.q_pop       (q_pop),
		.ctl         (b_ctl),
		.sum         (b_sum),
		.n           (b_n),
		.upc         (b_upc),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule
`default_nettype wire

>>> rtl/ura_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none
module ura_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire ura_pkg::result_t result
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> !result.busy_res)
		else $error("done word still busy");

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.trigger |-> result.busy_res)
		else $error("trigger driven while not busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.done_res
		|=> !(result_valid && result.done_res))
		else $error("two done words in a row");

endmodule

bind ultrasonic_range_averager ura_checker u_ura_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result)
);
`default_nettype wire

>>> verif/ultrasonic_range_averager_tb.sv
// Self-checking testbench of the ultrasonic range averager: directed and random ranging.
`default_nettype none
module ultrasonic_range_averager_tb;

	localparam logic [15:0] ECHO_TOP = '1;
	localparam int unsigned AVG_CAP = 16;
	localparam int unsigned RAND_TICKS = 550;
	localparam int unsigned RAND_AVERAGES = 12;
	localparam int unsigned RAND_ROUNDS = 4;
	localparam logic [ura_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 8'hA5;
	localparam logic [ura_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 8'h5A;

	localparam logic [2:0] RNG_IDLE  = 3'd0;
	localparam logic [2:0] RNG_TRIG  = 3'd1;
	localparam logic [2:0] RNG_WAIT  = 3'd2;
	localparam logic [2:0] RNG_COUNT = 3'd3;
	localparam logic [2:0] RNG_GAP   = 3'd4;

	logic                           clk;
	logic                           arst_n;
	logic                           tick_valid;
	logic                           tick_stall;
	ura_pkg::tick_t                 tick;
	logic                           result_valid;
	logic                           result_stall;
	ura_pkg::result_t               result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [ura_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ura_pkg::CFG_DATA_W-1:0] cfg_data;

	// shadow of the register file and the ranging state
	logic [9:0]  trig_len = ura_pkg::TRIGGER_US_RST;
	logic [19:0] gap_len = ura_pkg::GAP_US_RST;
	logic [4:0]  n_avg = ura_pkg::SAMPLE_COUNT_RST;
	logic [7:0]  us_cm = ura_pkg::US_PER_CM_RST;
	logic [2:0]  rng_phase = RNG_IDLE;
	logic [19:0] phase_ticks = '0;
	logic [15:0] echo_len = '0;
	logic [31:0] echo_total = '0;
	logic [4:0]  echoes_taken = '0;
	logic [22:0] last_avg = '0;

	ura_pkg::result_t range_words_due[$];
	int unsigned      averages_made = 0;
	int unsigned      bad_words = 0;
	int unsigned      rand_ticks_sent = 0;
	bit               tx_gaps = 1'b1;
	bit               rx_gaps = 1'b1;

	ultrasonic_range_averager dut (
		.clk,
		.arst_n,
		.tick_valid,
		.tick_stall,
		.tick,
		.result_valid,
		.result_stall,
		.result,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic ura_pkg::result_t advance_ranger(input ura_pkg::tick_t w);
		ura_pkg::result_t r;
		logic [19:0]      trig_w;
		int unsigned      n_eff;
		longint unsigned  quo;
		r = '0;
		trig_w = (trig_len == 0) ? 20'd1 : 20'(trig_len);
		n_eff = (n_avg == 0) ? 1 : ((n_avg > AVG_CAP) ? AVG_CAP : n_avg);
		case (rng_phase)
		RNG_IDLE: begin
			if (w.start_req) begin
				echo_total = '0;
				echoes_taken = '0;
				echo_len = '0;
				r.trigger = 1'b1;
				phase_ticks = 20'd1;
				rng_phase = (phase_ticks >= trig_w) ? RNG_WAIT : RNG_TRIG;
			end
		end
		RNG_TRIG: begin
			r.trigger = 1'b1;
			phase_ticks = phase_ticks + 1'b1;
			if (phase_ticks >= trig_w)
				rng_phase = RNG_WAIT;
		end
		RNG_WAIT: begin
			if (w.echo) begin
				echo_len = 16'd1;
				rng_phase = RNG_COUNT;
			end
		end
		RNG_COUNT: begin
			if (w.echo) begin
				if (echo_len != ECHO_TOP)
					echo_len = echo_len + 1'b1;
			end else begin
				echo_total = echo_total + echo_len;
				echoes_taken = echoes_taken + 1'b1;
				if (echoes_taken >= n_eff) begin
					quo = (64'(echo_total) * 64'd100) /
						(64'(n_eff) * ((us_cm == 0) ? 64'd1 : 64'(us_cm)));
					last_avg = (quo > 64'(ura_pkg::DIST_MAX)) ? ura_pkg::DIST_MAX
						: quo[22:0];
					r.done_res = 1'b1;
					averages_made++;
					rng_phase = RNG_IDLE;
				end else begin
					phase_ticks = '0;
					rng_phase = (gap_len == 0) ? RNG_TRIG : RNG_GAP;
				end
			end
		end
		RNG_GAP: begin
			phase_ticks = phase_ticks + 1'b1;
			if (phase_ticks >= gap_len) begin
				phase_ticks = '0;
				rng_phase = RNG_TRIG;
			end
		end
		default: rng_phase = RNG_IDLE;
		endcase
		r.busy_res = (rng_phase != RNG_IDLE);
		r.distance_centi_cm = last_avg;
		return r;
	endfunction

	task send_tick(input logic start, input logic echo_lvl);
		int unsigned    pause;
		ura_pkg::tick_t w;
		pause = tx_gaps ? $urandom_range(0, 8) : 0;
		w.start_req = start;
		w.echo = echo_lvl;
		repeat (pause) begin
			@(negedge clk);
			tick_valid <= 1'b0;
		end
		@(negedge clk);
		tick_valid <= 1'b1;
		tick <= w;
		do @(posedge clk); while (tick_stall !== 1'b0);
		range_words_due.push_back(advance_ranger(w));
	endtask

	task quiesce();
		@(negedge clk);
		tick_valid <= 1'b0;
		while (range_words_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(input logic [ura_pkg::CFG_IDX_W-1:0] idx,
		input logic [ura_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
		ura_pkg::REG_TRIGGER_US:   trig_len = val[9:0];
		ura_pkg::REG_GAP_US:       gap_len = val;
		ura_pkg::REG_SAMPLE_COUNT: n_avg = val[4:0];
		ura_pkg::REG_US_PER_CM:    us_cm = val[7:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task set_regs(input logic [ura_pkg::CFG_DATA_W-1:0] trig,
		input logic [ura_pkg::CFG_DATA_W-1:0] gap,
		input logic [ura_pkg::CFG_DATA_W-1:0] n,
		input logic [ura_pkg::CFG_DATA_W-1:0] upc);
		quiesce();
		write_reg(ura_pkg::REG_TRIGGER_US, trig);
		write_reg(ura_pkg::REG_GAP_US, gap);
		write_reg(ura_pkg::REG_SAMPLE_COUNT, n);
		write_reg(ura_pkg::REG_US_PER_CM, upc);
	endtask

	// runs ticks until echo is awaited (starting if idle), then one echo of hi_ticks
	task ping_echo(input int unsigned hi_ticks);
		while (rng_phase != RNG_WAIT)
			send_tick((rng_phase == RNG_IDLE) ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0);
		repeat (hi_ticks) send_tick(1'($urandom_range(0, 1)), 1'b1);
		send_tick(1'($urandom_range(0, 1)), 1'b0);
	endtask

	task test_defaults_and_live_regs();
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		ping_echo(3);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		quiesce();
		write_reg(ura_pkg::REG_GAP_US, 20'hFFFFF);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		quiesce();
		write_reg(ura_pkg::REG_GAP_US, 20'd0);
		write_reg(ura_pkg::REG_TRIGGER_US, 20'd0);
		write_reg(ura_pkg::REG_SAMPLE_COUNT, 20'd0);
		ping_echo(7);
		ping_echo(1);
	endtask

	task test_register_extremes();
		set_regs(20'hFFC00 | 20'd60, 20'd1000000, 20'hFFFE0 | 20'd31, 20'hFFF00 | 20'd255);
		write_reg(REG_SPARE_A, 20'($urandom));
		write_reg(REG_SPARE_B, 20'($urandom));
		ping_echo(5);
		repeat (3) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		quiesce();
		write_reg(ura_pkg::REG_GAP_US, 20'd1);
		write_reg(ura_pkg::REG_SAMPLE_COUNT, 20'd2);
		ping_echo(9);
		set_regs(20'd0, 20'd0, 20'd16, 20'd0);
		repeat (16) ping_echo($urandom_range(1, 30));
	endtask

	task test_random_ranging();
		int unsigned                    burst_left;
		int unsigned                    rounds;
		int unsigned                    avg_base;
		logic                           s;
		logic                           e;
		logic [ura_pkg::CFG_DATA_W-1:0] n;
		burst_left = 0;
		rounds = 0;
		avg_base = averages_made;
		while ((rand_ticks_sent < RAND_TICKS || averages_made - avg_base < RAND_AVERAGES)
			&& rounds < RAND_ROUNDS) begin
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
			0: n = 20'd0;
			1: n = 20'($urandom_range(17, 31));
			default: n = 20'($urandom_range(1, 3));
			endcase
			set_regs(($urandom_range(0, 9) == 0) ? 20'd40 : 20'($urandom_range(0, 6)),
				20'($urandom_range(0, 12)), n, 20'($urandom_range(0, 255)));
			repeat (150) begin
				e = ($urandom_range(0, 3) == 0);
				s = 1'($urandom_range(0, 1));
				case (rng_phase)
				RNG_IDLE: s = ($urandom_range(0, 2) != 0);
				RNG_WAIT: begin
					e = ($urandom_range(0, 2) == 0);
					if (e)
						burst_left = ($urandom_range(0, 15) == 0) ?
							$urandom_range(30, 200) : $urandom_range(0, 11);
				end
				RNG_COUNT: begin
					e = (burst_left != 0) && ($urandom_range(0, 19) != 0);
					if (burst_left != 0)
						burst_left--;
				end
				default: ;
				endcase
				if (rng_phase != RNG_IDLE || s)
					rand_ticks_sent++;
				send_tick(s, e);
			end
			rounds++;
		end
	endtask

	always @(posedge clk) begin : check_words
		ura_pkg::result_t want;
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			if (range_words_due.size() == 0) begin
				if (bad_words < 10)
					$display("unexpected result word %p", result);
				bad_words++;
			end else begin
				want = range_words_due.pop_front();
				if (result.trigger !== want.trigger || result.busy_res !== want.busy_res ||
					result.done_res !== want.done_res ||
					result.distance_centi_cm !== want.distance_centi_cm) begin
					if (bad_words < 10)
						$display({"mismatch: want trig %b busy %b done %b dist %0d,",
							" got trig %b busy %b done %b dist %0d"},
							want.trigger, want.busy_res, want.done_res, want.distance_centi_cm,
							result.trigger, result.busy_res, result.done_res,
							result.distance_centi_cm);
					bad_words++;
				end
			end
		end
	end

	initial begin : rx_side
		int unsigned hold;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = rx_gaps ? $urandom_range(0, 8) : 0;
			if (hold > 0) begin
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
				@(negedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (result_valid !== 1'b1);
		end
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		tick_valid <= 1'b0;
		tick <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_defaults_and_live_regs();
		test_register_extremes();
		test_random_ranging();
		quiesce();
		repeat (40) @(posedge clk);
		if (bad_words == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
